### rtl/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher.
package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int PERM_DEPTH = 256;
   localparam int PERM_AW    = 8;

   localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam logic STATUS_CIPHERED = 1'b0;
   localparam logic STATUS_NOT_KEYED = 1'b1;

   localparam logic [COUNT_W-1:0] KEY_LENGTH_RESET = COUNT_W'(16);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_INIT,
      ST_KS_RD,
      ST_KS_J,
      ST_KS_WI,
      ST_KS_WJ,
      ST_GEN_J,
      ST_GEN_WI,
      ST_GEN_WJ
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              status;
   } result_type;

endpackage

### rtl/rc4_ifs.sv
// Handshake channel interfaces of the RC4 stream cipher.
interface rc4_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [rc4_pkg::BYTE_W-1:0] value_byte;
   modport source (output valid, command, value_byte, input ready);
   modport sink (input valid, command, value_byte, output ready);
endinterface

interface rc4_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rc4_pkg::BYTE_W-1:0] out_byte;
   logic                       status;
   modport source (output valid, out_byte, status, input ready);
   modport sink (input valid, out_byte, status, output ready);
endinterface

interface rc4_csr_if;
   logic                        valid;
   logic                        ready;
   logic [rc4_pkg::COUNT_W-1:0] key_length;
   modport source (output valid, key_length, input ready);
   modport sink (input valid, key_length, output ready);
endinterface

### rtl/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: key-length register, engine and output register.
// A data beat after keying passes through ST_GEN_J, ST_GEN_WI and ST_GEN_WJ before its
// result enters the output register, and no new beat is taken until then, because of the
// read-swap-read sequence on the single permutation memory. A data beat before keying
// passes through ST_PASS to the output register, and no new beat is taken until then either.
// A key beat is taken in ST_IDLE; the last beat of a key adds the fill in ST_INIT and the schedule in the ST_KS states.
// Reset clears the key count, indices and keyed state and sets the key length to 16.
module rc4_stream_cipher #(
   parameter int KEY_STORE_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   rc4_req_if.sink    req_if,
   rc4_rsp_if.source  rsp_if,
   rc4_csr_if.sink    csr_if
);

   logic [rc4_pkg::COUNT_W-1:0] key_length_ff;
   logic                        rsp_valid_ff;
   rc4_pkg::result_type         rsp_data_ff;

   logic                res_valid;
   logic                res_ready;
   rc4_pkg::result_type res;
   logic                keyed;

   rc4_engine #(.KEY_STORE_DEPTH(KEY_STORE_DEPTH)) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_command    (req_if.command),
      .req_value_byte (req_if.value_byte),
      .key_length     (key_length_ff),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res),
      .keyed          (keyed)
   );

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= rc4_pkg::KEY_LENGTH_RESET;
      end else if (csr_if.valid) begin
         key_length_ff <= csr_if.key_length;
      end
   end

   // The output register frees itself in the same cycle that its beat is taken.
   assign res_ready = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_byte = rsp_data_ff.out_byte;
   assign rsp_if.status   = rsp_data_ff.status;

   a_no_accept_while_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_if.ready)
      else $error("input beat accepted while a result is pending in the engine");

   a_result_loads_output: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_valid_ff && (rsp_data_ff == $past(res)))
      else $error("engine result not captured by the output register");

   a_unkeyed_passes: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && (req_if.command == rc4_pkg::CMD_DATA) && !keyed
      |=> res_valid && (res.status == rc4_pkg::STATUS_NOT_KEYED)
          && (res.out_byte == $past(req_if.value_byte)))
      else $error("data beat before keying not returned unchanged");

   a_cipher_only_keyed: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status == rc4_pkg::STATUS_CIPHERED) |-> keyed)
      else $error("ciphered result produced without a key");

endmodule

### rtl/rc4_ram.sv
// Single-port-write, single-port-read byte memory with a registered read.
module rc4_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [rc4_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [rc4_pkg::BYTE_W-1:0] rd_data
);

   logic [rc4_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [rc4_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rc4_engine.sv
// Sequencer and datapath: key collection, key schedule and keystream generation.
module rc4_engine #(
   parameter int KEY_STORE_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [rc4_pkg::BYTE_W-1:0]   req_value_byte,
   input  logic [rc4_pkg::COUNT_W-1:0]  key_length,
   output logic                         res_valid,
   input  logic                         res_ready,
   output rc4_pkg::result_type          res,
   output logic                         keyed
);

   localparam int KIDX_W = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
   localparam logic [rc4_pkg::COUNT_W-1:0] DEPTH_C = rc4_pkg::COUNT_W'(KEY_STORE_DEPTH);
   localparam int BW = rc4_pkg::BYTE_W;
   localparam int CW = rc4_pkg::COUNT_W;
   localparam int AW = rc4_pkg::PERM_AW;

   rc4_pkg::state_type state_ff, state_in;

   logic [AW-1:0]     i_ff, i_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [AW-1:0]     n_ff, n_in;
   logic [KIDX_W-1:0] k_ff, k_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              keyed_ff, keyed_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [BW-1:0]     si_ff, si_in;
   logic [BW-1:0]     sj_ff, sj_in;
   logic [AW-1:0]     t_ff, t_in;
   logic [BW-1:0]     byte_ff, byte_in;

   logic              p_we, p_re;
   logic [AW-1:0]     p_waddr, p_raddr;
   logic [BW-1:0]     p_wdata, p_rdata;
   logic              k_we, k_re;
   logic [KIDX_W-1:0] k_waddr, k_raddr;
   logic [BW-1:0]     k_rdata;

   logic          accept;
   logic [CW-1:0] eff_len;
   logic [CW-1:0] cnt_base;
   logic [CW-1:0] cnt_next;
   logic          key_done;
   logic [CW-1:0] k_next;
   logic [AW-1:0] j_sum;
   logic [BW-1:0] keystream;

   rc4_ram #(.DEPTH(rc4_pkg::PERM_DEPTH), .AW(AW)) u_perm (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (p_re),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   rc4_ram #(.DEPTH(KEY_STORE_DEPTH), .AW(KIDX_W)) u_key (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_waddr),
      .wr_data (byte_in),
      .rd_en   (k_re),
      .rd_addr (k_raddr),
      .rd_data (k_rdata)
   );

   assign req_ready = (state_ff == rc4_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign keyed     = keyed_ff;

   always_comb begin
      if (key_length == '0) begin
         eff_len = CW'(1);
      end else if (key_length > DEPTH_C) begin
         eff_len = DEPTH_C;
      end else begin
         eff_len = key_length;
      end
   end

   // A key beat arriving after keying restarts the key at position zero.
   assign cnt_base = keyed_ff ? '0 : count_ff;
   assign cnt_next = cnt_base + CW'(1);
   assign key_done = (cnt_next >= eff_len);
   assign k_next   = {{(CW-KIDX_W){1'b0}}, k_ff} + CW'(1);

   // Swapped entries may still be in flight when S[t] is read, so t is compared
   // against both swap positions.
   always_comb begin
      if (t_ff == j_ff) begin
         keystream = si_ff;
      end else if (t_ff == i_ff) begin
         keystream = sj_ff;
      end else begin
         keystream = p_rdata;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == rc4_pkg::CMD_KEY) begin
                  state_in = key_done ? rc4_pkg::ST_INIT : rc4_pkg::ST_IDLE;
               end else begin
                  state_in = keyed_ff ? rc4_pkg::ST_GEN_J : rc4_pkg::ST_PASS;
               end
            end
         end
         rc4_pkg::ST_PASS: begin
            if (res_ready) begin
               state_in = rc4_pkg::ST_IDLE;
            end
         end
         rc4_pkg::ST_INIT: begin
            if (n_ff == rc4_pkg::PERM_LAST) begin
               state_in = rc4_pkg::ST_KS_RD;
            end
         end
         rc4_pkg::ST_KS_RD:  state_in = rc4_pkg::ST_KS_J;
         rc4_pkg::ST_KS_J:   state_in = rc4_pkg::ST_KS_WI;
         rc4_pkg::ST_KS_WI:  state_in = rc4_pkg::ST_KS_WJ;
         rc4_pkg::ST_KS_WJ: begin
            state_in = (n_ff == rc4_pkg::PERM_LAST) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KS_RD;
         end
         rc4_pkg::ST_GEN_J:  state_in = rc4_pkg::ST_GEN_WI;
         rc4_pkg::ST_GEN_WI: state_in = rc4_pkg::ST_GEN_WJ;
         rc4_pkg::ST_GEN_WJ: begin
            if (res_ready) begin
               state_in = rc4_pkg::ST_IDLE;
            end
         end
         default: state_in = rc4_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      count_in  = count_ff;
      keyed_in  = keyed_ff;
      len_in    = len_ff;
      si_in     = si_ff;
      sj_in     = sj_ff;
      t_in      = t_ff;
      byte_in   = byte_ff;
      p_we      = 1'b0;
      p_waddr   = n_ff;
      p_wdata   = n_ff;
      p_re      = 1'b0;
      p_raddr   = n_ff;
      k_we      = 1'b0;
      k_waddr   = cnt_base[KIDX_W-1:0];
      k_re      = 1'b0;
      k_raddr   = k_ff;
      j_sum     = j_ff + p_rdata;
      res_valid = 1'b0;
      res       = '{out_byte: byte_ff, status: rc4_pkg::STATUS_NOT_KEYED};
      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (accept) begin
               byte_in = req_value_byte;
               if (req_command == rc4_pkg::CMD_KEY) begin
                  k_we     = (cnt_base < DEPTH_C);
                  keyed_in = 1'b0;
                  if (key_done) begin
                     count_in = '0;
                     len_in   = eff_len;
                     n_in     = '0;
                  end else begin
                     count_in = cnt_next;
                  end
               end else if (keyed_ff) begin
                  i_in    = i_ff + AW'(1);
                  p_re    = 1'b1;
                  p_raddr = i_ff + AW'(1);
               end
            end
         end
         rc4_pkg::ST_PASS: begin
            res_valid = 1'b1;
         end
         rc4_pkg::ST_INIT: begin
            p_we = 1'b1;
            n_in = n_ff + AW'(1);
            j_in = '0;
            k_in = '0;
         end
         rc4_pkg::ST_KS_RD: begin
            p_re = 1'b1;
            k_re = 1'b1;
         end
         rc4_pkg::ST_KS_J: begin
            j_sum   = j_ff + p_rdata + k_rdata;
            j_in    = j_sum;
            si_in   = p_rdata;
            p_re    = 1'b1;
            p_raddr = j_sum;
         end
         rc4_pkg::ST_KS_WI: begin
            p_we    = 1'b1;
            p_wdata = p_rdata;
         end
         rc4_pkg::ST_KS_WJ: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            n_in    = n_ff + AW'(1);
            k_in    = (k_next >= len_ff) ? '0 : k_next[KIDX_W-1:0];
            if (n_ff == rc4_pkg::PERM_LAST) begin
               keyed_in = 1'b1;
               i_in     = '0;
               j_in     = '0;
            end
         end
         rc4_pkg::ST_GEN_J: begin
            j_in    = j_sum;
            si_in   = p_rdata;
            p_re    = 1'b1;
            p_raddr = j_sum;
         end
         rc4_pkg::ST_GEN_WI: begin
            p_we    = 1'b1;
            p_waddr = i_ff;
            p_wdata = p_rdata;
            sj_in   = p_rdata;
            t_in    = si_ff + p_rdata;
            p_re    = 1'b1;
            p_raddr = si_ff + p_rdata;
         end
         rc4_pkg::ST_GEN_WJ: begin
            p_we      = 1'b1;
            p_waddr   = j_ff;
            p_wdata   = si_ff;
            res_valid = 1'b1;
            res       = '{out_byte: byte_ff ^ keystream, status: rc4_pkg::STATUS_CIPHERED};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rc4_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         count_ff <= '0;
         keyed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         count_ff <= count_in;
         keyed_ff <= keyed_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      k_ff    <= k_in;
      len_ff  <= len_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      byte_ff <= byte_in;
   end

endmodule
